// File: rtl/lbo_pkg.sv
// Shared types, constants and helpers of the label border overlay unit.
package lbo_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int LABEL_BITS_DEF = 16;

	// Fixed field widths of the transfers and of the configuration port.
	localparam int LABEL_FIELD_W = 16;
	localparam int RGB_W         = 24;
	localparam int CFG_DATA_W    = 33;
	localparam int REG_IDX_W     = 3;
	localparam int STYLE_W       = 33;

	// Register reset values.
	localparam logic [11:0]        WIDTH_RST  = 12'd2048;
	localparam logic [15:0]        HEIGHT_RST = 16'd2048;
	localparam logic [2:0]         CHAN_RST   = 3'b111;
	localparam logic [STYLE_W-1:0] STYLE_RST  = '0;

	// Item kinds on the input channel.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THICK_MODE   = 3'd0,
		REG_IMAGE_WIDTH  = 3'd1,
		REG_IMAGE_HEIGHT = 3'd2,
		REG_CHAN_ENABLE  = 3'd3,
		REG_BORDER_STYLE = 3'd4,
		REG_BODY_STYLE   = 3'd5,
		REG_EDGE_STYLE   = 3'd6
	} lbo_reg_t;

	typedef enum logic [1:0] {
		CLS_BACKGROUND = 2'd0,
		CLS_BORDER     = 2'd1,
		CLS_BODY       = 2'd2,
		CLS_EDGE       = 2'd3
	} lbo_cls_t;

	typedef struct packed {
		logic                     kind;
		logic [LABEL_FIELD_W-1:0] label;
		logic [7:0]               src_red;
		logic [7:0]               src_green;
		logic [7:0]               src_blue;
	} lbo_pix_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		lbo_cls_t   pixel_class;
		logic       frame_end;
	} lbo_res_t;

	// Per-item control decided when the item is taken in.
	typedef struct packed {
		logic emit;       // item produces a result
		logic wr_center;  // pixel item: write the current row buffers
		logic left_ok;    // left neighbour lies inside the image
		logic right_ok;   // right neighbour lies inside the image
		logic up_ok;      // neighbour above lies inside the image
		logic has_down;   // neighbour below is the incoming label
		logic boundary;   // pixel sits on the image boundary
		logic frame_end;  // last result of the frame
	} lbo_job_t;

	// Stored label width: the label field is 16 bits wide at most.
	function automatic int lbo_label_w(input int label_bits);
		return (label_bits < LABEL_FIELD_W) ? label_bits : LABEL_FIELD_W;
	endfunction

endpackage

// File: rtl/label_border_overlay_unit.sv
// Top level of the label border overlay unit: config registers, line buffers, pipeline.
// Throughput is one transfer per clock on both channels, drain items included, while the result side is not stalled.
// A taken item passes through stage 1 and then the result register before its result transfer.
// A pixel's result is made when the pixel directly below it is taken in, one row later; the
// last row is made by the drain items.
// Reset clears the raster counters, pipeline valid bits and config registers to defaults.
module label_border_overlay_unit #(
	parameter int MAX_WIDTH  = lbo_pkg::MAX_WIDTH_DEF,
	parameter int LABEL_BITS = lbo_pkg::LABEL_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Pixel and drain items.
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  lbo_pkg::lbo_pix_t               pix_data,
	// Results.
	output logic                            res_valid,
	input  logic                            res_stall,
	output lbo_pkg::lbo_res_t               res_data,
	// Configuration writes.
	input  logic                            cfg_write_en,
	input  logic [lbo_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [lbo_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lbo_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = lbo_label_w(LABEL_BITS);
	localparam int CE = LW + RGB_W;

	// Configuration registers.
	logic               thick_mode_q;
	logic [11:0]        image_width_q;
	logic [15:0]        image_height_q;
	logic [2:0]         chan_enable_q;
	logic [STYLE_W-1:0] border_style_q;
	logic [STYLE_W-1:0] body_style_q;
	logic [STYLE_W-1:0] edge_style_q;

	// Intake.
	logic          pix_accept;
	logic          take;
	logic          take_now;
	logic [CW-1:0] front_col;
	lbo_job_t      front_job;

	// Stage 1: the item waits here while its line-buffer reads come back.
	logic          valid_s1;
	lbo_job_t      job_s1;
	logic [CW-1:0] col_s1;
	logic [LW-1:0] lab_s1;
	logic [RGB_W-1:0] rgb_s1;

	// Stage 2: the result register.
	logic          valid_s2;
	lbo_res_t      data_s2;

	logic          advance;
	logic          fire;
	logic [CW-1:0] rd_col;
	logic [CW-1:0] rd_col_nxt;
	logic [CE-1:0] center_rd;
	logic [LW-1:0] right_rd;
	logic [LW-1:0] above_rd;
	logic [LW-1:0] left_q;
	lbo_res_t      shade_res;

	// Configuration writes are registered; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_mode_q   <= 1'b0;
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
			chan_enable_q  <= CHAN_RST;
			border_style_q <= STYLE_RST;
			body_style_q   <= STYLE_RST;
			edge_style_q   <= STYLE_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_THICK_MODE:   thick_mode_q   <= cfg_data[0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[15:0];
				REG_CHAN_ENABLE:  chan_enable_q  <= cfg_data[2:0];
				REG_BORDER_STYLE: border_style_q <= cfg_data[STYLE_W-1:0];
				REG_BODY_STYLE:   body_style_q   <= cfg_data[STYLE_W-1:0];
				REG_EDGE_STYLE:   edge_style_q   <= cfg_data[STYLE_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the result register is free or being emptied.
	// Stage 1 leaves whenever the pipeline moves, so intake only stalls when
	// stage 1 is full and the result side is stalled.
	assign advance    = !valid_s2 || !res_stall;
	assign pix_stall  = valid_s1 && !advance;
	assign pix_accept = pix_valid && !pix_stall;
	assign fire       = valid_s1 && advance;

	lbo_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (pix_accept),
		.kind      (pix_data.kind),
		.cfg_width (image_width_q),
		.cfg_height(image_height_q),
		.take      (take),
		.col       (front_col),
		.job       (front_job)
	);

	// Items that fall outside the frame are taken off the channel and dropped.
	assign take_now = pix_accept && take;

	// Reads are issued in the intake cycle for the incoming item and repeated
	// for the item held in stage 1, so the read data stays valid under a stall.
	assign rd_col     = take_now ? front_col : col_s1;
	assign rd_col_nxt = (rd_col == CW'(MAX_WIDTH - 1)) ? rd_col : rd_col + CW'(1);

	// Current row: label and colour at the pixel's column.
	lbo_fwd_ram #(
		.WIDTH(CE),
		.DEPTH(MAX_WIDTH)
	) u_center (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fire && job_s1.wr_center),
		.wr_addr(col_s1),
		.wr_data({lab_s1, rgb_s1}),
		.rd_addr(rd_col),
		.rd_data(center_rd)
	);

	// Copy of the current row labels, read one column ahead for the right neighbour.
	lbo_fwd_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fire && job_s1.wr_center),
		.wr_addr(col_s1),
		.wr_data(lab_s1),
		.rd_addr(rd_col_nxt),
		.rd_data(right_rd)
	);

	// Row above the pixel being classified; refilled as the current row is shaded.
	lbo_fwd_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_above (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fire && job_s1.emit),
		.wr_addr(col_s1),
		.wr_data(center_rd[CE-1:RGB_W]),
		.rd_addr(rd_col),
		.rd_data(above_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_now) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= fire && job_s1.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_now) begin
			job_s1 <= front_job;
			col_s1 <= front_col;
			lab_s1 <= pix_data.label[LW-1:0];
			rgb_s1 <= {pix_data.src_red, pix_data.src_green, pix_data.src_blue};
		end
		// The left neighbour is the label of the previous shaded pixel.
		if (fire && job_s1.emit) begin
			left_q <= center_rd[CE-1:RGB_W];
		end
		if (fire && job_s1.emit) begin
			data_s2 <= shade_res;
		end
	end

	lbo_shade #(
		.LABEL_BITS(LABEL_BITS)
	) u_shade (
		.job         (job_s1),
		.val         (center_rd[CE-1:RGB_W]),
		.left        (left_q),
		.right       (right_rd),
		.up          (above_rd),
		.down        (lab_s1),
		.rgb         (center_rd[RGB_W-1:0]),
		.thick_mode  (thick_mode_q),
		.chan_enable (chan_enable_q),
		.border_style(border_style_q),
		.body_style  (body_style_q),
		.edge_style  (edge_style_q),
		.res         (shade_res)
	);

	assign res_valid = valid_s2;
	assign res_data  = data_s2;

endmodule

// File: rtl/lbo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lbo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/lbo_fwd_ram.sv
// Line buffer: RAM plus forwarding of a write that hits the address being read.
module lbo_fwd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] ram_data;
	logic [WIDTH-1:0] fwd_data_q;
	logic             hit_q;

	lbo_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(ram_data)
	);

	// A read that meets a write to the same entry returns the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
	end

	assign rd_data = hit_q ? fwd_data_q : ram_data;

endmodule

// File: rtl/lbo_front.sv
// Raster position counters and per-item control decisions at intake.
module lbo_front #(
	parameter int MAX_WIDTH = lbo_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         kind,
	input  logic [11:0]                  cfg_width,
	input  logic [15:0]                  cfg_height,
	output logic                         take,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output lbo_pkg::lbo_job_t            job
);
	import lbo_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WB = $clog2(MAX_WIDTH + 1);

	logic [CW-1:0] in_col_q;
	logic [CW-1:0] out_col_q;
	logic [15:0]   in_row_q;
	logic [15:0]   out_row_q;
	logic [WB-1:0] eff_w;
	logic [15:0]   eff_h;
	logic [WB-1:0] col_p1;
	logic          full;
	logic          is_pixel;
	logic          right_ok;

	always_comb begin
		if (cfg_width == '0) begin
			eff_w = WB'(1);
		end else if (32'(cfg_width) > MAX_WIDTH) begin
			eff_w = WB'(MAX_WIDTH);
		end else begin
			eff_w = WB'(cfg_width);
		end
		eff_h = (cfg_height == '0) ? 16'd1 : cfg_height;
	end

	assign full     = in_row_q >= eff_h;
	assign is_pixel = kind == KIND_PIXEL;
	assign col      = is_pixel ? in_col_q : out_col_q;
	assign col_p1   = WB'(col) + WB'(1);
	assign right_ok = col_p1 < eff_w;

	// Pixels count only until all rows are in; drains only after that.
	assign take = is_pixel ? !full : full;

	always_comb begin
		job.left_ok  = col != '0;
		job.right_ok = right_ok;
		if (is_pixel) begin
			job.emit      = in_row_q != '0;
			job.wr_center = 1'b1;
			job.up_ok     = in_row_q > 16'd1;
			job.has_down  = 1'b1;
			job.frame_end = 1'b0;
		end else begin
			job.emit      = 1'b1;
			job.wr_center = 1'b0;
			job.up_ok     = out_row_q != '0;
			job.has_down  = 1'b0;
			job.frame_end = !right_ok;
		end
		// The drained row is always the bottom row of the image.
		job.boundary = !job.left_ok || !right_ok || !job.up_ok || !is_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			in_row_q  <= '0;
			out_row_q <= '0;
		end else if (accept && take) begin
			if (is_pixel) begin
				if (right_ok) begin
					in_col_q  <= CW'(col_p1);
					out_col_q <= CW'(col_p1);
					out_row_q <= (in_row_q == '0) ? '0 : in_row_q - 16'd1;
				end else begin
					in_col_q  <= '0;
					out_col_q <= '0;
					in_row_q  <= in_row_q + 16'd1;
					out_row_q <= in_row_q;
				end
			end else if (!right_ok) begin
				in_col_q  <= '0;
				out_col_q <= '0;
				in_row_q  <= '0;
				out_row_q <= '0;
			end else begin
				out_col_q <= CW'(col_p1);
			end
		end
	end

endmodule

// File: rtl/lbo_shade.sv
// Pixel classification from the neighbour labels and per-class alpha blending.
module lbo_shade #(
	parameter int LABEL_BITS = lbo_pkg::LABEL_BITS_DEF
) (
	input  lbo_pkg::lbo_job_t                            job,
	input  logic [lbo_pkg::lbo_label_w(LABEL_BITS)-1:0]  val,
	input  logic [lbo_pkg::lbo_label_w(LABEL_BITS)-1:0]  left,
	input  logic [lbo_pkg::lbo_label_w(LABEL_BITS)-1:0]  right,
	input  logic [lbo_pkg::lbo_label_w(LABEL_BITS)-1:0]  up,
	input  logic [lbo_pkg::lbo_label_w(LABEL_BITS)-1:0]  down,
	input  logic [lbo_pkg::RGB_W-1:0]                    rgb,
	input  logic                                         thick_mode,
	input  logic [2:0]                                   chan_enable,
	input  logic [lbo_pkg::STYLE_W-1:0]                  border_style,
	input  logic [lbo_pkg::STYLE_W-1:0]                  body_style,
	input  logic [lbo_pkg::STYLE_W-1:0]                  edge_style,
	output lbo_pkg::lbo_res_t                            res
);
	import lbo_pkg::*;

	logic                diff;
	logic                bg;
	lbo_cls_t            cls;
	logic [STYLE_W-1:0]  style;
	logic [8:0]          alpha;
	logic [7:0]          ch_r;
	logic [7:0]          ch_g;
	logic [7:0]          ch_b;

	// (src*(256-a) + col*a + 128) >> 8, written as src*256 + (col-src)*a.
	function automatic logic [7:0] blend(input logic [7:0] src, input logic [7:0] colr,
	                                     input logic [8:0] a);
		logic signed [9:0]  d;
		logic signed [9:0]  as;
		logic signed [19:0] p;
		logic signed [19:0] s;
		d  = $signed({2'b00, colr}) - $signed({2'b00, src});
		as = $signed({1'b0, a});
		p  = d * as;
		s  = $signed({4'b0000, src, 8'h00}) + p + 20'sd128;
		return s[15:8];
	endfunction

	assign diff = (job.left_ok && (left != val)) || (job.right_ok && (right != val)) ||
	              (job.up_ok && (up != val)) || (job.has_down && (down != val));
	assign bg   = val == '0;

	always_comb begin
		if (thick_mode) begin
			if (diff) begin
				cls = CLS_BORDER;
			end else if (bg) begin
				cls = CLS_BACKGROUND;
			end else begin
				cls = job.boundary ? CLS_EDGE : CLS_BODY;
			end
		end else begin
			if (bg) begin
				cls = CLS_BACKGROUND;
			end else if (diff) begin
				cls = CLS_BORDER;
			end else begin
				cls = job.boundary ? CLS_EDGE : CLS_BODY;
			end
		end
	end

	always_comb begin
		case (cls)
			CLS_BORDER: style = border_style;
			CLS_BODY:   style = body_style;
			CLS_EDGE:   style = edge_style;
			default:    style = '0;
		endcase
		alpha = (style[32:24] > 9'd256) ? 9'd256 : style[32:24];
	end

	always_comb begin
		if (cls == CLS_BACKGROUND) begin
			ch_r = rgb[23:16];
			ch_g = rgb[15:8];
			ch_b = rgb[7:0];
		end else begin
			ch_r = blend(rgb[23:16], style[23:16], alpha);
			ch_g = blend(rgb[15:8], style[15:8], alpha);
			ch_b = blend(rgb[7:0], style[7:0], alpha);
		end
		res.out_red     = chan_enable[0] ? ch_r : 8'h00;
		res.out_green   = chan_enable[1] ? ch_g : 8'h00;
		res.out_blue    = chan_enable[2] ? ch_b : 8'h00;
		res.pixel_class = cls;
		res.frame_end   = job.frame_end;
	end

endmodule
